// ===== rtl/lhw_pkg.sv =====
// ----------------------------------------------------------------------------
// lhw_pkg
// shared types and constants of the link health watchdog
// ----------------------------------------------------------------------------
package lhw_pkg;

	// event codes
	typedef enum logic [1:0] {
		ACT_PERIOD_CHECK = 2'd0,
		ACT_ADDR_ACQUIRED = 2'd1,
		ACT_LINK_LOST = 2'd2
	} action_t;

	// command codes
	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_DISCONNECT = 2'd1,
		CMD_REBOOT = 2'd2,
		CMD_RECONNECT = 2'd3
	} command_t;

	// configuration register indexes
	localparam logic [1:0] REG_MISS_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_CYCLE_LIMIT = 2'd1;
	localparam logic [1:0] REG_KICK_INTERVAL = 2'd2;
	localparam logic [1:0] REG_REBOOT_INTERVAL = 2'd3;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 32;

	// register reset values
	localparam logic [7:0] MISS_THRESHOLD_RST = 8'd4;
	localparam logic [7:0] CYCLE_LIMIT_RST = 8'd3;
	localparam logic [31:0] KICK_INTERVAL_RST = 32'd180000;
	localparam logic [31:0] REBOOT_INTERVAL_RST = 32'd600000;

	localparam logic [7:0] KICK_COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] time_now;
		logic probe_alive;
		logic gateway_known;
	} event_t;

	typedef struct packed {
		logic [1:0] command;
		logic link_up;
	} result_t;

	typedef struct packed {
		logic [7:0] miss_threshold;
		logic [7:0] cycle_limit;
		logic [31:0] kick_interval;
		logic [31:0] reboot_interval;
	} cfg_t;

	typedef struct packed {
		logic have_address;
		logic gateway_valid;
		logic [7:0] miss_count;
		logic [7:0] cycle_count;
		logic [7:0] kick_count;
		logic [31:0] last_proof_time;
		logic [31:0] lost_since_time;
	} state_t;

endpackage

// ===== rtl/link_health_watchdog_core.sv =====
// ----------------------------------------------------------------------------
// link_health_watchdog_core
// escalating link supervision watchdog, one command per event item
// ----------------------------------------------------------------------------
// the item passes through the input register and then the result register before result_valid rises
// throughput: one item per cycle unless result_ready stalls the result register, set by the state update loop
// reset: arst_n clears the state and loads the register defaults at once
// the block is ready immediately after reset
module link_health_watchdog_core (
	input logic clk,
	input logic arst_n,
	input logic event_valid,
	output logic event_ready,
	input lhw_pkg::event_t event_data,
	output logic result_valid,
	input logic result_ready,
	output lhw_pkg::result_t result_data,
	input logic cfg_write_en,
	input logic [lhw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [lhw_pkg::CFG_DATA_W-1:0] cfg_data
);

	lhw_pkg::cfg_t cfg;
	lhw_pkg::state_t state_q;
	lhw_pkg::state_t state_next;
	lhw_pkg::event_t event_s1;
	logic valid_s1;
	lhw_pkg::result_t result_s2;
	lhw_pkg::result_t step_result;
	logic valid_s2;
	logic advance_s1;

	lhw_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	lhw_step u_step (
		.ev(event_s1),
		.state(state_q),
		.cfg(cfg),
		.state_next(state_next),
		.result(step_result)
	);

	// handshake: stage 1 moves on when the result register is free or drains
	assign advance_s1 = valid_s1 && (!valid_s2 || result_ready);
	assign event_ready = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (event_ready) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ready && event_valid) begin
			event_s1 <= event_data;
		end
	end

	// watchdog state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2 <= step_result;
		end
	end

	assign result_valid = valid_s2;
	assign result_data = result_s2;

endmodule

// ===== rtl/lhw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// lhw_cfg_regs
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
module lhw_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_write_en,
	input logic [lhw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [lhw_pkg::CFG_DATA_W-1:0] cfg_data,
	output lhw_pkg::cfg_t cfg
);

	lhw_pkg::cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.miss_threshold <= lhw_pkg::MISS_THRESHOLD_RST;
			cfg_q.cycle_limit <= lhw_pkg::CYCLE_LIMIT_RST;
			cfg_q.kick_interval <= lhw_pkg::KICK_INTERVAL_RST;
			cfg_q.reboot_interval <= lhw_pkg::REBOOT_INTERVAL_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				lhw_pkg::REG_MISS_THRESHOLD: cfg_q.miss_threshold <= cfg_data[7:0];
				lhw_pkg::REG_CYCLE_LIMIT: cfg_q.cycle_limit <= cfg_data[7:0];
				lhw_pkg::REG_KICK_INTERVAL: cfg_q.kick_interval <= cfg_data;
				lhw_pkg::REG_REBOOT_INTERVAL: cfg_q.reboot_interval <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/lhw_step.sv =====
// ----------------------------------------------------------------------------
// lhw_step
// next-state and command logic for one event item
// ----------------------------------------------------------------------------
module lhw_step (
	input lhw_pkg::event_t ev,
	input lhw_pkg::state_t state,
	input lhw_pkg::cfg_t cfg,
	output lhw_pkg::state_t state_next,
	output lhw_pkg::result_t result
);

	logic [31:0] proof_elapsed;
	logic [31:0] lost_elapsed;
	logic [8:0] kick_mult;
	logic [40:0] kick_limit;
	logic reboot_due;
	logic kick_due;
	logic [7:0] miss_inc;
	logic [7:0] cycle_inc;
	lhw_pkg::state_t clear_st;
	lhw_pkg::command_t cmd;

	// elapsed times, wrapping
	assign proof_elapsed = ev.time_now - state.last_proof_time;
	assign lost_elapsed = ev.time_now - state.lost_since_time;

	// kick deadline grows with each kick, full width so it never wraps
	assign kick_mult = {1'b0, state.kick_count} + 9'd1;
	assign kick_limit = 41'(cfg.kick_interval) * 41'(kick_mult);

	assign reboot_due = proof_elapsed >= cfg.reboot_interval;
	assign kick_due = 41'(lost_elapsed) >= kick_limit;

	assign miss_inc = state.miss_count + 8'd1;
	assign cycle_inc = state.cycle_count + 8'd1;

	// state after a reboot
	always_comb begin
		clear_st = '0;
		clear_st.last_proof_time = ev.time_now;
		clear_st.lost_since_time = ev.time_now;
	end

	// event handling
	always_comb begin
		state_next = state;
		cmd = lhw_pkg::CMD_NONE;
		unique case (ev.action)
			lhw_pkg::ACT_PERIOD_CHECK: begin
				if (reboot_due) begin
					state_next = clear_st;
					cmd = lhw_pkg::CMD_REBOOT;
				end else if (!state.have_address || !state.gateway_valid) begin
					if (kick_due) begin
						if (state.kick_count != lhw_pkg::KICK_COUNT_MAX) begin
							state_next.kick_count = state.kick_count + 8'd1;
						end
						cmd = lhw_pkg::CMD_DISCONNECT;
					end
				end else if (ev.probe_alive) begin
					state_next.kick_count = '0;
					state_next.miss_count = '0;
					state_next.cycle_count = '0;
					state_next.last_proof_time = ev.time_now;
				end else if (miss_inc < cfg.miss_threshold) begin
					state_next.kick_count = '0;
					state_next.miss_count = miss_inc;
				end else if (cycle_inc >= cfg.cycle_limit) begin
					state_next = clear_st;
					cmd = lhw_pkg::CMD_REBOOT;
				end else begin
					// run of misses: force a disconnect
					state_next.kick_count = '0;
					state_next.miss_count = '0;
					state_next.cycle_count = cycle_inc;
					state_next.lost_since_time = ev.time_now;
					state_next.have_address = 1'b0;
					cmd = lhw_pkg::CMD_DISCONNECT;
				end
			end
			lhw_pkg::ACT_ADDR_ACQUIRED: begin
				state_next.have_address = 1'b1;
				state_next.gateway_valid = ev.gateway_known;
				state_next.last_proof_time = ev.time_now;
				state_next.miss_count = '0;
			end
			lhw_pkg::ACT_LINK_LOST: begin
				if (state.have_address) begin
					state_next.lost_since_time = ev.time_now;
				end
				state_next.have_address = 1'b0;
				cmd = lhw_pkg::CMD_RECONNECT;
			end
			default: begin
				// unused code leaves everything alone
				state_next = state;
			end
		endcase
	end

	assign result.command = cmd;
	assign result.link_up = state_next.have_address;

endmodule
